@@ design/opem_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package opem_pkg;

	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 24;
	localparam int FRAC_W   = 24;
	localparam int ENV_W    = 28;
	localparam int MAG_W    = 24;
	localparam int OUT_W    = 24;
	localparam int MULA_W   = ENV_W + 1;
	localparam int PROD_W   = MULA_W + COEF_W;
	localparam int CFG_IDX_W = 3;

	// Follower ceiling of 20.0 in unsigned 5.23.
	localparam logic [ENV_W-1:0] ENV_MAX   = 28'd167772160;
	// Largest magnitude of a signed 1.23 sample.
	localparam logic [MAG_W-1:0] MAG_MAX   = 24'd8388608;
	localparam logic [OUT_W-1:0] METER_MAX = 24'hFFFFFF;

	localparam logic [COEF_W-1:0] FAST_ATTACK_RST = 24'd349525;
	localparam logic [COEF_W-1:0] SLOW_ATTACK_RST = 24'd1502959;
	localparam logic [COEF_W-1:0] DECAY_RST       = 24'd16776604;
	localparam logic [COEF_W-1:0] GAIN_RST        = 24'd8422162;

	localparam logic [CFG_IDX_W-1:0] REG_FAST_ATTACK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_ATTACK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_ONLY   = 3'd4;

	localparam logic [1:0] FUNC_SAMPLE = 2'd0;
	localparam logic [1:0] FUNC_READ   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DEC_F,
		OP_DEC_S,
		OP_FOL_F,
		OP_FOL_S,
		OP_METER
	} op_t;

endpackage

`default_nettype wire

@@ design/oversampled_peak_envelope_meter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Oversampled peak envelope meter.
// Input channel: in_valid / in_stall carry one transaction with func, first_in_block and
// four signed 1.23 samples. A transaction is taken at a clock edge with in_valid high and
// in_stall low. func selects a sample group, a read that arms a restart, or a clear.
// Output channel: out_valid / out_stall return exactly one transaction (meter_value,
// peak_value) for every input transaction, in order.
// Configuration channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high and registers should only be written while the block is idle.
// Schedule: a sample group runs 2*OVERSAMPLE+5 steps through one shared 29x24 multiplier,
// at most one product issued per cycle with the fast and slow followers interleaved,
// then the output register is loaded. Read, clear and the unused code go straight to the
// output register. No new transaction is taken until the last one has been loaded into
// the output register; the shared multiplier and the dependence of each follower update
// on the one before set the pace of a sample group.
// Reset clears both followers and the held values, arms a restart and loads the register
// defaults. While out_stall holds a result, the block finishes its current transaction and
// then waits with in_stall high until the output register is free.
module oversampled_peak_envelope_meter #(
	parameter int OVERSAMPLE = 4
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       in_valid,
	output logic                                      in_stall,
	input  wire  [1:0]                                func,
	input  wire                                       first_in_block,
	input  wire  signed [opem_pkg::SAMPLE_W-1:0]      sample_a,
	input  wire  signed [opem_pkg::SAMPLE_W-1:0]      sample_b,
	input  wire  signed [opem_pkg::SAMPLE_W-1:0]      sample_c,
	input  wire  signed [opem_pkg::SAMPLE_W-1:0]      sample_d,
	output logic                                      out_valid,
	input  wire                                       out_stall,
	output logic [opem_pkg::OUT_W-1:0]                meter_value,
	output logic [opem_pkg::OUT_W-1:0]                peak_value,
	input  wire                                       cfg_valid,
	output logic                                      cfg_ready,
	input  wire  [opem_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  wire  [opem_pkg::COEF_W-1:0]               cfg_data
);
	import opem_pkg::*;

	// Step schedule: 0 and 1 decay the fast and slow followers, then fast and slow follower
	// updates alternate for every sample, one bubble lets the last slow update land, the
	// meter product is issued, and the last step writes it back.
	localparam int FOL_FIRST  = 2;
	localparam int FOL_LAST   = 2 * OVERSAMPLE + 1;
	localparam int METER_STEP = 2 * OVERSAMPLE + 3;
	localparam int LAST_STEP  = 2 * OVERSAMPLE + 4;
	localparam int STEP_W     = $clog2(LAST_STEP + 1);

	// Configuration registers.
	logic [COEF_W-1:0] fast_rate_q;
	logic [COEF_W-1:0] slow_rate_q;
	logic [COEF_W-1:0] decay_q;
	logic [COEF_W-1:0] gain_q;
	logic              peak_only_q;

	// Block state.
	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [ENV_W-1:0]  env_fast_q;
	logic [ENV_W-1:0]  env_slow_q;
	logic [OUT_W-1:0]  held_meter_q;
	logic [MAG_W-1:0]  held_peak_q;
	logic              restart_armed_q;
	logic [SAMPLE_W-1:0] samp_q [4];

	// Shared multiplier and its writeback stage.
	logic [MULA_W-1:0] mul_a;
	logic [COEF_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;
	op_t               op_issue;
	logic              hit_issue;
	logic [PROD_W-1:0] prod_s1;
	op_t               op_s1;
	logic              hit_s1;

	// Output register.
	logic              out_valid_q;
	logic [OUT_W-1:0]  meter_value_q;
	logic [OUT_W-1:0]  peak_value_q;

	logic              in_take;
	logic              out_load;
	logic              run_last;
	logic              in_fol;
	logic              fast_slot;
	logic [STEP_W-1:0] rel_step;
	logic [1:0]        samp_sel;
	logic [SAMPLE_W-1:0] cur_samp;
	logic [MAG_W-1:0]  cur_mag;
	logic [MAG_W-1:0]  diff_fast;
	logic [MAG_W-1:0]  diff_slow;
	logic [ENV_W-1:0]  scaled;
	logic [ENV_W:0]    fol_sum_fast;
	logic [ENV_W:0]    fol_sum_slow;
	logic [MULA_W-1:0] cand;
	logic [OUT_W-1:0]  cand_sat;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign meter_value = meter_value_q;
	assign peak_value  = peak_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_rate_q <= FAST_ATTACK_RST;
			slow_rate_q <= SLOW_ATTACK_RST;
			decay_q     <= DECAY_RST;
			gain_q      <= GAIN_RST;
			peak_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FAST_ATTACK: fast_rate_q <= cfg_data;
				REG_SLOW_ATTACK: slow_rate_q <= cfg_data;
				REG_DECAY:       decay_q     <= cfg_data;
				REG_GAIN:        gain_q      <= cfg_data;
				REG_PEAK_ONLY:   peak_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sample selection: sample k of a group is input sample k mod 4.
	assign rel_step  = step_q - STEP_W'(FOL_FIRST);
	assign samp_sel  = rel_step[2:1];
	assign fast_slot = !rel_step[0];
	assign in_fol    = (state_q == ST_RUN) && (step_q >= STEP_W'(FOL_FIRST))
		&& (step_q <= STEP_W'(FOL_LAST));
	assign run_last  = (state_q == ST_RUN) && (step_q == STEP_W'(LAST_STEP));
	assign cur_samp  = samp_q[samp_sel];
	// Two's complement magnitude; the most negative code maps to 1.0.
	assign cur_mag   = cur_samp[SAMPLE_W-1] ? MAG_W'(~cur_samp + 1'b1) : cur_samp;
	assign diff_fast = cur_mag - env_fast_q[MAG_W-1:0];
	assign diff_slow = cur_mag - env_slow_q[MAG_W-1:0];

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		op_issue  = OP_NONE;
		hit_issue = 1'b0;
		if ((state_q == ST_RUN) && !peak_only_q) begin
			if (step_q == STEP_W'(0)) begin
				mul_a    = {1'b0, env_fast_q};
				mul_b    = decay_q;
				op_issue = OP_DEC_F;
			end else if (step_q == STEP_W'(1)) begin
				mul_a    = {1'b0, env_slow_q};
				mul_b    = decay_q;
				op_issue = OP_DEC_S;
			end else if (in_fol && fast_slot) begin
				// The difference is only meaningful when the magnitude lies above.
				hit_issue = {{(ENV_W-MAG_W){1'b0}}, cur_mag} > env_fast_q;
				mul_a     = MULA_W'(diff_fast);
				mul_b     = fast_rate_q;
				op_issue  = OP_FOL_F;
			end else if (in_fol) begin
				hit_issue = {{(ENV_W-MAG_W){1'b0}}, cur_mag} > env_slow_q;
				mul_a     = MULA_W'(diff_slow);
				mul_b     = slow_rate_q;
				op_issue  = OP_FOL_S;
			end else if (step_q == STEP_W'(METER_STEP)) begin
				mul_a    = {1'b0, env_fast_q} + {1'b0, env_slow_q};
				mul_b    = gain_q;
				op_issue = OP_METER;
			end
		end
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		hit_s1  <= hit_issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= op_issue;
		end
	end

	// Writeback arithmetic: every product is truncated by the coefficient's fraction.
	assign scaled       = prod_s1[FRAC_W +: ENV_W];
	assign fol_sum_fast = {1'b0, env_fast_q} + {1'b0, scaled};
	assign fol_sum_slow = {1'b0, env_slow_q} + {1'b0, scaled};
	assign cand         = prod_s1[FRAC_W +: MULA_W];
	assign cand_sat     = (|cand[MULA_W-1:OUT_W]) ? METER_MAX : cand[OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (in_take) begin
			samp_q[0] <= sample_a;
			samp_q[1] <= sample_b;
			samp_q[2] <= sample_c;
			samp_q[3] <= sample_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_fast_q      <= '0;
			env_slow_q      <= '0;
			held_meter_q    <= '0;
			held_peak_q     <= '0;
			restart_armed_q <= 1'b1;
		end else if (in_take) begin
			case (func)
				FUNC_SAMPLE: begin
					if (first_in_block && restart_armed_q) begin
						held_meter_q <= '0;
						held_peak_q  <= '0;
						if (!peak_only_q) begin
							restart_armed_q <= 1'b0;
						end
					end
				end
				FUNC_READ: begin
					restart_armed_q <= 1'b1;
				end
				FUNC_CLEAR: begin
					held_meter_q    <= '0;
					held_peak_q     <= '0;
					restart_armed_q <= 1'b1;
				end
				default: ;
			endcase
		end else begin
			// The raw maximum is tracked once per sample, on the fast slot.
			if (in_fol && fast_slot) begin
				if (peak_only_q) begin
					if (cur_mag > held_meter_q) begin
						held_meter_q <= cur_mag;
					end
				end else if (cur_mag > held_peak_q) begin
					held_peak_q <= cur_mag;
				end
			end
			case (op_s1)
				OP_DEC_F: env_fast_q <= scaled;
				OP_DEC_S: env_slow_q <= scaled;
				OP_FOL_F: begin
					if (hit_s1) begin
						env_fast_q <= (fol_sum_fast > {1'b0, ENV_MAX}) ? ENV_MAX
							: fol_sum_fast[ENV_W-1:0];
					end
				end
				OP_FOL_S: begin
					if (hit_s1) begin
						env_slow_q <= (fol_sum_slow > {1'b0, ENV_MAX}) ? ENV_MAX
							: fol_sum_slow[ENV_W-1:0];
					end
				end
				OP_METER: begin
					if (cand_sat > held_meter_q) begin
						held_meter_q <= cand_sat;
					end
				end
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (func == FUNC_SAMPLE) ? ST_RUN : ST_FIN;
				end
			end
			ST_RUN: begin
				if (run_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (run_last) begin
			step_q <= '0;
		end else if (state_q == ST_RUN) begin
			step_q <= step_q + 1'b1;
		end
	end

	// Output register; it takes the held values once the transaction is complete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			meter_value_q <= held_meter_q;
			peak_value_q  <= held_peak_q;
		end
	end

	// The followers never pass their ceiling.
	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(env_fast_q <= ENV_MAX) && (env_slow_q <= ENV_MAX))
		else $error("follower above its ceiling");

	// The held raw peak is always a valid magnitude.
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_peak_q <= MAG_MAX)
		else $error("held peak above full scale");

	// A taken transaction closes the input until it has been answered.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input taken while busy");

	// The step counter stays within the schedule.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_W'(LAST_STEP))
		else $error("step counter out of range");

	// The output register is only loaded when it is free or being drained.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ tb/peak_meter_checker.sv @@
`timescale 1ns / 1ps

// Watches the input, output and register channels of the peak envelope meter,
// predicts the held levels for every accepted input transaction and compares each
// output transaction with the oldest prediction.
module peak_meter_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	input  wire                                 in_stall,
	input  wire  [1:0]                          func,
	input  wire                                 first_in_block,
	input  wire  [opem_pkg::SAMPLE_W-1:0]       sample_a,
	input  wire  [opem_pkg::SAMPLE_W-1:0]       sample_b,
	input  wire  [opem_pkg::SAMPLE_W-1:0]       sample_c,
	input  wire  [opem_pkg::SAMPLE_W-1:0]       sample_d,
	input  wire                                 out_valid,
	input  wire                                 out_stall,
	input  wire  [opem_pkg::OUT_W-1:0]          meter_value,
	input  wire  [opem_pkg::OUT_W-1:0]          peak_value,
	input  wire                                 cfg_valid,
	input  wire                                 cfg_ready,
	input  wire  [opem_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [opem_pkg::COEF_W-1:0]         cfg_data,
	output int                                  fail_count,
	output int                                  pending_count
);

	import opem_pkg::*;

	localparam int GROUP = 4;

	typedef struct packed {
		logic [OUT_W-1:0] meter;
		logic [OUT_W-1:0] peak;
	} held_levels_t;

	held_levels_t expected_levels_q[$];
	int mismatches = 0;

	logic [COEF_W-1:0] fast_rate  = FAST_ATTACK_RST;
	logic [COEF_W-1:0] slow_rate  = SLOW_ATTACK_RST;
	logic [COEF_W-1:0] decay_coef = DECAY_RST;
	logic [COEF_W-1:0] gain_coef  = GAIN_RST;
	logic              peak_only  = 1'b0;

	logic [ENV_W-1:0]  env_fast      = '0;
	logic [ENV_W-1:0]  env_slow      = '0;
	logic [OUT_W-1:0]  held_meter    = '0;
	logic [OUT_W-1:0]  held_peak     = '0;
	logic              restart_armed = 1'b1;

	function automatic logic [MAG_W-1:0] magnitude(logic [SAMPLE_W-1:0] s);
		return s[SAMPLE_W-1] ? (24'd0 - s) : s;
	endfunction

	// Unsigned product with a 0.24 coefficient, truncated.
	function automatic logic [63:0] frac_mul(logic [63:0] x, logic [COEF_W-1:0] c);
		return (x * 64'(c)) >> FRAC_W;
	endfunction

	// One attack step of a follower toward a magnitude above it.
	function automatic logic [ENV_W-1:0] chase(logic [ENV_W-1:0] env, logic [MAG_W-1:0] v,
		logic [COEF_W-1:0] rate);
		logic [63:0] ev;
		logic [63:0] vv;
		logic [63:0] next;
		ev = 64'(env);
		vv = 64'(v);
		if (vv <= ev)
			return env;
		next = ev + frac_mul(vv - ev, rate);
		if (next > 64'(ENV_MAX))
			next = 64'(ENV_MAX);
		return next[ENV_W-1:0];
	endfunction

	task automatic reset_state();
		fast_rate     = FAST_ATTACK_RST;
		slow_rate     = SLOW_ATTACK_RST;
		decay_coef    = DECAY_RST;
		gain_coef     = GAIN_RST;
		peak_only     = 1'b0;
		env_fast      = '0;
		env_slow      = '0;
		held_meter    = '0;
		held_peak     = '0;
		restart_armed = 1'b1;
		expected_levels_q.delete();
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
		case (idx)
			REG_FAST_ATTACK: fast_rate  = data;
			REG_SLOW_ATTACK: slow_rate  = data;
			REG_DECAY:       decay_coef = data;
			REG_GAIN:        gain_coef  = data;
			REG_PEAK_ONLY:   peak_only  = data[0];
			default: ;
		endcase
	endtask

	task automatic step_levels(logic [1:0] f, logic first, logic [SAMPLE_W-1:0] s0,
		logic [SAMPLE_W-1:0] s1, logic [SAMPLE_W-1:0] s2, logic [SAMPLE_W-1:0] s3);
		logic [MAG_W-1:0] mags [GROUP];
		logic [63:0]      env_sum;
		logic [63:0]      cand;
		held_levels_t     lv;
		int               k;
		mags[0] = magnitude(s0);
		mags[1] = magnitude(s1);
		mags[2] = magnitude(s2);
		mags[3] = magnitude(s3);
		case (f)
			FUNC_SAMPLE: begin
				if (first && restart_armed) begin
					held_meter = '0;
					held_peak  = '0;
					if (!peak_only)
						restart_armed = 1'b0;
				end
				if (peak_only) begin
					// The followers stay frozen; the meter holds the raw maximum.
					for (k = 0; k < GROUP; k++)
						if (mags[k] > held_meter)
							held_meter = mags[k];
				end else begin
					env_fast = ENV_W'(frac_mul(64'(env_fast), decay_coef));
					env_slow = ENV_W'(frac_mul(64'(env_slow), decay_coef));
					for (k = 0; k < GROUP; k++) begin
						env_fast = chase(env_fast, mags[k], fast_rate);
						env_slow = chase(env_slow, mags[k], slow_rate);
						if (mags[k] > held_peak)
							held_peak = mags[k];
					end
					env_sum = 64'(env_fast);
					env_sum = env_sum + 64'(env_slow);
					cand = frac_mul(env_sum, gain_coef);
					if (cand > 64'(METER_MAX))
						cand = 64'(METER_MAX);
					if (cand[OUT_W-1:0] > held_meter)
						held_meter = cand[OUT_W-1:0];
				end
			end
			FUNC_READ: restart_armed = 1'b1;
			FUNC_CLEAR: begin
				held_meter    = '0;
				held_peak     = '0;
				restart_armed = 1'b1;
			end
			default: ;
		endcase
		lv.meter = held_meter;
		lv.peak  = held_peak;
		expected_levels_q.push_back(lv);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		held_levels_t want;
		if (!arst_n) begin
			reset_state();
			pending_count <= 0;
			fail_count    <= mismatches;
		end else begin
			// Results are retired before new work is queued, so a result cannot
			// match a transaction accepted at the same edge.
			if (out_valid && !out_stall) begin
				if (expected_levels_q.size() == 0) begin
					$error("unexpected result: meter_value %0d, peak_value %0d",
						meter_value, peak_value);
					mismatches++;
				end else begin
					want = expected_levels_q.pop_front();
					if (meter_value !== want.meter) begin
						$error("meter_value: expected %0d, actual %0d", want.meter,
							meter_value);
						mismatches++;
					end
					if (peak_value !== want.peak) begin
						$error("peak_value: expected %0d, actual %0d", want.peak,
							peak_value);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				step_levels(func, first_in_block, sample_a, sample_b, sample_c, sample_d);
			pending_count <= expected_levels_q.size();
			fail_count    <= mismatches;
		end
	end

endmodule

@@ tb/oversampled_peak_envelope_meter_tb.sv @@
`timescale 1ns / 1ps

// Top of the meter testbench. It generates the clock and the single reset, drives
// input transactions and register writes, shapes the back-pressure on the result
// channel and gives the verdict. All prediction and comparison live in the checker
// that sits beside the block and watches the same wires.
module oversampled_peak_envelope_meter_tb;

	import opem_pkg::*;

	// The block answers the spare function code with the held values and no change.
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam logic [COEF_W-1:0] COEF_FULL = 24'hFFFFFF;
	localparam logic [COEF_W-1:0] COEF_ZERO = 24'h000000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               func;
	logic                     first_in_block;
	logic signed [SAMPLE_W-1:0] sample_a;
	logic signed [SAMPLE_W-1:0] sample_b;
	logic signed [SAMPLE_W-1:0] sample_c;
	logic signed [SAMPLE_W-1:0] sample_d;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [OUT_W-1:0]         meter_value;
	logic [OUT_W-1:0]         peak_value;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [COEF_W-1:0]        cfg_data;

	int fail_count;
	int pending_count;

	// Sender pacing: in a bursty phase the sender pushes a run of back-to-back
	// transactions and then goes quiet for a random number of cycles.
	bit steady = 1'b0;
	int burst_left = 0;

	// Receiver pacing state.
	int stall_mode = 0;
	int stall_left = 0;

	int n_sample = 0;
	int n_read = 0;
	int n_clear = 0;
	int n_spare = 0;
	int n_starts = 0;
	int n_settings = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	oversampled_peak_envelope_meter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.first_in_block (first_in_block),
		.sample_a       (sample_a),
		.sample_b       (sample_b),
		.sample_c       (sample_c),
		.sample_d       (sample_d),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.meter_value    (meter_value),
		.peak_value     (peak_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	peak_meter_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.first_in_block (first_in_block),
		.sample_a       (sample_a),
		.sample_b       (sample_b),
		.sample_c       (sample_c),
		.sample_d       (sample_d),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.meter_value    (meter_value),
		.peak_value     (peak_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending_count  (pending_count)
	);

	// The receiver switches between a few stall patterns: never stalling, rare
	// random stalls, heavy random stalls, and a periodic stall.
	// Each pattern holds for a random stretch, so stalls land on every phase of
	// the block's sequencing.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 160);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_left % 32) < 12);
		endcase
	end

	// A quiet stretch on the input channel. The payload is scrambled while valid
	// is low, which the block must ignore.
	task automatic sender_gap(int cycles);
		in_valid       <= 1'b0;
		func           <= 2'($urandom);
		first_in_block <= 1'($urandom);
		sample_a       <= SAMPLE_W'($urandom);
		sample_b       <= SAMPLE_W'($urandom);
		sample_c       <= SAMPLE_W'($urandom);
		sample_d       <= SAMPLE_W'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic pace();
		if (steady)
			return;
		if (burst_left == 0) begin
			sender_gap($urandom_range(1, 20));
			burst_left = $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	// Present one input transaction and hold it until the block takes it. Valid is
	// left high so that a following transaction goes out back to back.
	task automatic send(logic [1:0] f, logic first, logic [SAMPLE_W-1:0] a,
		logic [SAMPLE_W-1:0] b, logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] d);
		in_valid       <= 1'b1;
		func           <= f;
		first_in_block <= first;
		sample_a       <= a;
		sample_b       <= b;
		sample_c       <= c;
		sample_d       <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		case (f)
			FUNC_SAMPLE: n_sample++;
			FUNC_READ:   n_read++;
			FUNC_CLEAR:  n_clear++;
			default:     n_spare++;
		endcase
		if (f == FUNC_SAMPLE && first)
			n_starts++;
		pace();
	endtask

	// Stop sending and wait for every outstanding result. The first clock is always
	// waited out so that the count includes a transaction taken at the current edge.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only with the block idle, so the meter is drained first.
	task automatic apply_settings(logic [COEF_W-1:0] fast, logic [COEF_W-1:0] slow,
		logic [COEF_W-1:0] decay, logic [COEF_W-1:0] gain, logic peak_mode);
		drain_results();
		write_reg(REG_FAST_ATTACK, fast);
		write_reg(REG_SLOW_ATTACK, slow);
		write_reg(REG_DECAY, decay);
		write_reg(REG_GAIN, gain);
		write_reg(REG_PEAK_ONLY, {23'd0, peak_mode});
		n_settings++;
	endtask

	// Sample values lean on the interesting points: both full-scale ends, zero,
	// tiny values around zero and mid-level signals, with plain random words for
	// the rest so that every bit toggles.
	function automatic logic [SAMPLE_W-1:0] pick_sample(bit quiet);
		if (quiet)
			return ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom_range(0, 15)) : 24'd0;
		case ($urandom_range(0, 9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			3: return 24'd0 - SAMPLE_W'($urandom_range(0, 255));
			4: return SAMPLE_W'($urandom_range(0, 255));
			5: return SAMPLE_W'($urandom_range(0, 24'h0FFFFF));
			6: return 24'd0 - SAMPLE_W'($urandom_range(0, 24'h0FFFFF));
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Most random traffic is well-formed: an optional read that arms a restart,
	// then a processing block whose first sample group is marked. Some blocks are
	// near silence so the followers decay. The rest is noise: any function code
	// with a random block marker.
	task automatic random_traffic(int count);
		int  sent;
		int  len;
		int  j;
		bit  quiet;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 4) != 0) begin
				if ($urandom_range(0, 1)) begin
					send(FUNC_READ, 1'($urandom), SAMPLE_W'($urandom),
						SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
					sent++;
				end
				len   = $urandom_range(1, 8);
				quiet = ($urandom_range(0, 5) == 0);
				for (j = 0; j < len; j++) begin
					send(FUNC_SAMPLE, (j == 0), pick_sample(quiet), pick_sample(quiet),
						pick_sample(quiet), pick_sample(quiet));
					sent++;
				end
			end else begin
				send(2'($urandom_range(0, 3)), 1'($urandom), pick_sample(1'b0),
					pick_sample(1'b0), pick_sample(1'b0), pick_sample(1'b0));
				sent++;
			end
		end
	endtask

	initial begin
		int ph;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		func           = FUNC_SAMPLE;
		first_in_block = 1'b0;
		sample_a       = '0;
		sample_b       = '0;
		sample_c       = '0;
		sample_d       = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_FAST_ATTACK;
		cfg_data       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, starting from the reset register values. The first marked
		// group after reset restarts the hold because a restart is armed at reset.
		send(FUNC_SAMPLE, 1'b1, 24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF);
		send(FUNC_SAMPLE, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send(FUNC_SAMPLE, 1'b0, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
		send(FUNC_READ, 1'b0, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
		// A restart armed in the middle of a block waits for the next marked group.
		send(FUNC_SAMPLE, 1'b0, 24'h000100, 24'hFFFF00, 24'h000001, 24'hFFFFFF);
		send(FUNC_SAMPLE, 1'b1, 24'h400000, 24'hC00000, 24'h000001, 24'h800001);
		// A second marked group without a read in between keeps holding.
		send(FUNC_SAMPLE, 1'b1, 24'h000010, 24'h000010, 24'h000010, 24'h000010);
		send(FUNC_CLEAR, 1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
		send(FUNC_SPARE, 1'b1, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
		send(FUNC_SAMPLE, 1'b0, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
		send(FUNC_READ, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send(FUNC_READ, 1'b0, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
		send(FUNC_CLEAR, 1'b1, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
		send(FUNC_SAMPLE, 1'b1, 24'h123456, 24'hEDCBAA, 24'h000000, 24'h7FFFFF);

		// Full-scale coefficients drive the followers toward full scale and the meter sum
		// toward its ceiling.
		apply_settings(COEF_FULL, COEF_FULL, COEF_FULL, COEF_FULL, 1'b0);
		send(FUNC_SAMPLE, 1'b1, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
		send(FUNC_SAMPLE, 1'b0, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
		send(FUNC_SAMPLE, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);

		// Peak-only mode leaves the restart armed, so every marked group restarts.
		apply_settings(FAST_ATTACK_RST, SLOW_ATTACK_RST, DECAY_RST, GAIN_RST, 1'b1);
		send(FUNC_SAMPLE, 1'b1, 24'h200000, 24'hE00000, 24'h000003, 24'h7FFFFF);
		send(FUNC_SAMPLE, 1'b1, 24'h000040, 24'hFFFFC0, 24'h000000, 24'h000001);
		send(FUNC_SAMPLE, 1'b0, 24'h800000, 24'h000000, 24'h000000, 24'h000000);
		send(FUNC_READ, 1'b0, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
		send(FUNC_SPARE, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		send(FUNC_CLEAR, 1'b0, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
		send(FUNC_SAMPLE, 1'b0, 24'h000200, 24'h000000, 24'h000000, 24'h000000);

		// Zero coefficients: the followers decay to zero and never attack, so the meter stays at zero.
		apply_settings(COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, 1'b0);
		send(FUNC_SAMPLE, 1'b1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);

		// Random phases, each under its own register setting. Every third phase
		// runs with the sender never idling.
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: apply_settings(FAST_ATTACK_RST, SLOW_ATTACK_RST, DECAY_RST, GAIN_RST, 1'b0);
				1: apply_settings(COEF_FULL, COEF_FULL, COEF_FULL, COEF_FULL, 1'b0);
				2: apply_settings(COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, 1'b0);
				3: apply_settings(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
					COEF_W'($urandom), 1'b1);
				default: apply_settings(COEF_W'($urandom), COEF_W'($urandom),
					$urandom_range(0, 1) ? COEF_W'($urandom_range(24'hF00000, 24'hFFFFFF))
						: COEF_W'($urandom),
					COEF_W'($urandom), 1'($urandom_range(0, 1)));
			endcase
			steady     = (ph % 3 == 1);
			burst_left = 0;
			random_traffic(115);
		end

		drain_results();
		// Let the block sit idle a little so that a stray extra result is caught.
		repeat (40) @(posedge clk);

		$display("Sent %0d transactions: %0d sample groups (%0d block starts),",
			n_sample + n_read + n_clear + n_spare, n_sample, n_starts);
		$display("%0d reads, %0d clears, %0d spare codes.", n_read, n_clear, n_spare);
		$display("Ran under %0d register settings, including full-scale, zero and peak-only.",
			n_settings);
		if (fail_count == 0 && pending_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// A generous ceiling on the whole run, far above the slowest legal pacing.
	initial begin
		#(20_000_000);
		$display("status: fail");
		$finish;
	end

endmodule
